// File: rtl/core/lpa_pkg.sv
`default_nettype none
package lpa_pkg;

  // register indexes on the configuration port
  localparam logic [2:0] REG_BW       = 3'd0;
  localparam logic [2:0] REG_SF       = 3'd1;
  localparam logic [2:0] REG_CR       = 3'd2;
  localparam logic [2:0] REG_PRE      = 3'd3;
  localparam logic [2:0] REG_CRC      = 3'd4;
  localparam logic [2:0] REG_EXPL     = 3'd5;
  localparam logic [2:0] REG_FIXLEN   = 3'd6;

  // result status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_INVALID   = 2'd1;
  localparam logic [1:0] ST_OVERFLOW  = 2'd2;

  // datapath widths
  localparam int NUM_W   = 42;  // rounded-up numerator
  localparam int DIV_W   = 21;  // four times the bandwidth
  localparam int RECIP_W = 18;  // reciprocal constant
  localparam int RECIP_SH = 20; // reciprocal scale

  typedef struct packed {
    logic [18:0] bw_hz;
    logic [3:0]  sf;
    logic [3:0]  cr;
    logic [15:0] pre;
    logic        crc;
    logic        expl;
    logic [7:0]  fixlen;
  } cfg_t;

  // numerator handed from the symbol pipeline to the divider
  typedef struct packed {
    logic             ok;
    logic [NUM_W-1:0] num;
  } num_t;

  // quotient leaving the divider
  typedef struct packed {
    logic             ok;
    logic [NUM_W-1:0] quo;
  } quo_t;

  // snap a raw bandwidth to a standard value, zero when unknown
  function automatic logic [18:0] snap_bw(input logic [18:0] raw);
    logic [18:0] r;
    case (raw)
      19'd7800, 19'd7812:     r = 19'd7812;
      19'd10400, 19'd10417:   r = 19'd10417;
      19'd15600, 19'd15625:   r = 19'd15625;
      19'd20800, 19'd20833:   r = 19'd20833;
      19'd31250:              r = 19'd31250;
      19'd41667, 19'd41700:   r = 19'd41667;
      19'd62500:              r = 19'd62500;
      19'd125000:             r = 19'd125000;
      19'd250000:             r = 19'd250000;
      19'd500000:             r = 19'd500000;
      default:                r = 19'd0;
    endcase
    return r;
  endfunction

  // ceil(2^20 / k) for the symbol divisor k in 5..12
  function automatic logic [RECIP_W-1:0] recip(input logic [3:0] k);
    logic [RECIP_W-1:0] m;
    case (k)
      4'd5:    m = 18'd209716;
      4'd6:    m = 18'd174763;
      4'd7:    m = 18'd149797;
      4'd8:    m = 18'd131072;
      4'd9:    m = 18'd116509;
      4'd10:   m = 18'd104858;
      4'd11:   m = 18'd95326;
      4'd12:   m = 18'd87382;
      default: m = 18'd0;
    endcase
    return m;
  endfunction

endpackage
`default_nettype wire

// File: rtl/core/lpa_cfg.sv
`default_nettype none
module lpa_cfg (
  input  wire               clk,
  input  wire               rst,
  input  wire               cfg_we,
  input  wire         [2:0] cfg_index,
  input  wire        [18:0] cfg_data,
  output lpa_pkg::cfg_t     cfg
);
  import lpa_pkg::*;

  // modem setting registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.bw_hz  <= 19'd125000;
      cfg.sf     <= 4'd7;
      cfg.cr     <= 4'd5;
      cfg.pre    <= 16'd8;
      cfg.crc    <= 1'b1;
      cfg.expl   <= 1'b1;
      cfg.fixlen <= 8'd0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_BW:     cfg.bw_hz  <= cfg_data;
        REG_SF:     cfg.sf     <= cfg_data[3:0];
        REG_CR:     cfg.cr     <= cfg_data[3:0];
        REG_PRE:    cfg.pre    <= cfg_data[15:0];
        REG_CRC:    cfg.crc    <= cfg_data[0];
        REG_EXPL:   cfg.expl   <= cfg_data[0];
        REG_FIXLEN: cfg.fixlen <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire

// File: rtl/core/lpa_sym.sv
`default_nettype none
module lpa_sym (
  input  wire                        clk,
  input  wire                        rst,
  input  wire                        en,
  input  lpa_pkg::cfg_t              cfg,
  input  wire  [18:0]                bw_snap,
  input  wire  [lpa_pkg::DIV_W-1:0]  bw4_m1,
  input  wire                        in_valid,
  input  wire  [7:0]                 payload_len,
  output logic                       out_valid,
  output lpa_pkg::num_t              out_num
);
  import lpa_pkg::*;

  // stage 1 signals
  logic               s1_valid, s1_ok, s1_small;
  logic [3:0]         s1_k, s1_sf, s1_cr;
  logic signed [12:0] s1_bits;
  logic [15:0]        s1_pre;
  logic               c_ok, c_small, c_ldro;
  logic signed [12:0] c_bits;
  logic [3:0]         c_k;
  logic [19:0]        sym_lhs, sym_rhs;

  // stage 2 signals
  logic        s2_valid, s2_ok, s2_small, s2_pos;
  logic [3:0]  s2_sf, s2_cr;
  logic [15:0] s2_pre;
  logic [28:0] s2_prod;
  logic [9:0]  c_x;
  logic [10:0] c_y;

  // stage 3 signals
  logic        s3_valid, s3_ok;
  logic [3:0]  s3_sf;
  logic [19:0] s3_quarters;
  logic [8:0]  c_q;
  logic [12:0] c_coded;

  // stage 4 signals
  logic             s4_valid, s4_ok;
  logic [NUM_W-1:0] s4_num;
  logic [31:0]      c_shift;

  // settings check, low data rate decision and coded bit count
  always_comb begin
    c_ok = (bw_snap != 19'd0) && (cfg.sf >= 4'd5) && (cfg.sf <= 4'd12) &&
           (cfg.cr >= 4'd5) && (cfg.cr <= 4'd8) && (cfg.pre != 16'd0) &&
           (cfg.expl || ((cfg.fixlen != 8'd0) && (payload_len == cfg.fixlen)));
    c_small = (cfg.sf <= 4'd6);
    sym_lhs = 20'(({8'd0, 12'd1} << cfg.sf[3:0])) * 20'd125;
    sym_rhs = {bw_snap, 1'b0};
    c_ldro  = (sym_lhs >= sym_rhs);
    c_bits  = $signed({2'b00, payload_len, 3'b000}) - $signed({7'd0, cfg.sf, 2'b00}) +
              (cfg.crc ? 13'sd16 : 13'sd0);
    if (c_small) begin
      c_bits = c_bits + (cfg.expl ? 13'sd20 : 13'sd0);
    end else begin
      c_bits = c_bits + (cfg.expl ? 13'sd28 : 13'sd8);
    end
    c_k = (!c_small && c_ldro) ? cfg.sf - 4'd2 : cfg.sf;
  end

  // ceil(bits / 4k) as a reciprocal product
  always_comb begin
    c_x = (s1_bits > 13'sd0) ? 10'((s1_bits + 13'sd3) >>> 2) : 10'd0;
    c_y = {1'b0, c_x} + {7'd0, s1_k} - 11'd1;
  end

  // coded symbols and quarter-symbol count
  always_comb begin
    c_q     = s2_pos ? 9'(s2_prod >> RECIP_SH) : 9'd0;
    c_coded = {4'd0, c_q} * {9'd0, s2_cr};
  end

  assign c_shift = 32'({12'd0, s3_quarters} << s3_sf);

  // valid bits travel with the data
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      s3_valid  <= 1'b0;
      s4_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      s1_valid  <= in_valid;
      s2_valid  <= s1_valid;
      s3_valid  <= s2_valid;
      s4_valid  <= s3_valid;
      out_valid <= s4_valid;
    end
  end

  // payload stages
  always_ff @(posedge clk) begin
    if (en) begin
      s1_ok    <= c_ok;
      s1_small <= c_small;
      s1_k     <= c_k;
      s1_sf    <= cfg.sf;
      s1_cr    <= cfg.cr;
      s1_bits  <= c_bits;
      s1_pre   <= cfg.pre;

      s2_ok    <= s1_ok;
      s2_small <= s1_small;
      s2_pos   <= (s1_bits > 13'sd0);
      s2_sf    <= s1_sf;
      s2_cr    <= s1_cr;
      s2_pre   <= s1_pre;
      s2_prod  <= {18'd0, c_y} * {11'd0, recip(s1_k)};

      s3_ok       <= s2_ok;
      s3_sf       <= s2_sf;
      s3_quarters <= {2'd0, s2_pre, 2'b00} + (s2_small ? 20'd57 : 20'd49) +
                     {5'd0, c_coded, 2'b00};

      s4_ok  <= s3_ok;
      s4_num <= {10'd0, c_shift} * 42'd1000;

      out_num.ok  <= s4_ok;
      out_num.num <= s4_num + {{(NUM_W-DIV_W){1'b0}}, bw4_m1};
    end
  end

endmodule
`default_nettype wire

// File: rtl/core/lpa_div.sv
`default_nettype none
module lpa_div (
  input  wire                        clk,
  input  wire                        rst,
  input  wire                        en,
  input  wire  [lpa_pkg::DIV_W-1:0]  divisor,
  input  wire                        in_valid,
  input  lpa_pkg::num_t              in_num,
  output logic                       out_valid,
  output lpa_pkg::quo_t              out_quo
);
  import lpa_pkg::*;

  // one quotient bit per stage, restoring
  logic             vl  [0:NUM_W];
  logic             okv [0:NUM_W];
  logic [NUM_W-1:0] dn  [0:NUM_W];
  logic [NUM_W-1:0] qt  [0:NUM_W];
  logic [DIV_W-1:0] rm  [0:NUM_W];

  assign vl[0]  = in_valid;
  assign okv[0] = in_num.ok;
  assign dn[0]  = in_num.num;
  assign qt[0]  = '0;
  assign rm[0]  = '0;

  for (genvar i = 0; i < NUM_W; i++) begin : g_stage
    logic [DIV_W:0] trial;
    logic           fits;

    // bring down the next dividend bit and try the subtract
    always_comb begin
      trial = {rm[i], dn[i][NUM_W-1]};
      fits  = (trial >= {1'b0, divisor});
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vl[i+1] <= 1'b0;
      end else if (en) begin
        vl[i+1] <= vl[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        okv[i+1] <= okv[i];
        dn[i+1]  <= {dn[i][NUM_W-2:0], 1'b0};
        qt[i+1]  <= {qt[i][NUM_W-2:0], fits};
        rm[i+1]  <= fits ? DIV_W'(trial - {1'b0, divisor}) : trial[DIV_W-1:0];
      end
    end
  end

  assign out_valid   = vl[NUM_W];
  assign out_quo.ok  = okv[NUM_W];
  assign out_quo.quo = qt[NUM_W];

endmodule
`default_nettype wire

// File: rtl/core/lora_packet_airtime_top.sv
`default_nettype none
// LoRa packet time on air. Each payload length on the input stream yields one
// result: the time on air in milliseconds, rounded up, on m_tdata and a status
// on m_tuser (ok, invalid settings or length, overflow; the time is zero
// unless ok). Modem settings are written through the cfg port; the user must
// write them only while no item is in flight, which the block does not enforce.
// One length is taken every clock cycle unless the output stalls. The path is
// 48 register stages deep: the five-stage symbol count pipeline, the 42-stage
// bit-per-stage divider by four times the bandwidth and the output register.
// The whole pipeline holds while a finished result waits on m_tready, and no
// length is taken during reset.
module lora_packet_airtime_top (
  input  wire         clk,
  input  wire         rst,
  // configuration writes
  input  wire         cfg_we,
  input  wire   [2:0] cfg_index,
  input  wire  [18:0] cfg_data,
  // payload length stream
  input  wire         s_tvalid,
  output logic        s_tready,
  input  wire   [7:0] s_tdata,   // [7:0] payload_len
  // airtime stream
  output logic        m_tvalid,
  input  wire         m_tready,
  output logic [31:0] m_tdata,   // [31:0] airtime_ms
  output logic  [1:0] m_tuser    // [1:0] status
);
  import lpa_pkg::*;

  cfg_t             cfg;
  logic [18:0]      bw_snap;
  logic [DIV_W-1:0] bw4;
  logic [DIV_W-1:0] bw4_m1;
  logic             en;
  logic             num_valid, quo_valid;
  num_t             num;
  quo_t             quo;

  lpa_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // divisor from the snapped bandwidth
  assign bw_snap = snap_bw(cfg.bw_hz);
  assign bw4     = {bw_snap, 2'b00};
  assign bw4_m1  = bw4 - DIV_W'(1);

  // pipeline advances unless a result is stuck at the output
  assign en       = !m_tvalid || m_tready;
  assign s_tready = en && !rst;

  lpa_sym u_sym (
    .clk         (clk),
    .rst         (rst),
    .en          (en),
    .cfg         (cfg),
    .bw_snap     (bw_snap),
    .bw4_m1      (bw4_m1),
    .in_valid    (s_tvalid),
    .payload_len (s_tdata),
    .out_valid   (num_valid),
    .out_num     (num)
  );

  lpa_div u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .divisor   (bw4),
    .in_valid  (num_valid),
    .in_num    (num),
    .out_valid (quo_valid),
    .out_quo   (quo)
  );

  // output register with status
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (en) begin
      m_tvalid <= quo_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (!quo.ok) begin
        m_tdata <= 32'd0;
        m_tuser <= ST_INVALID;
      end else if (quo.quo[NUM_W-1:32] != '0) begin
        m_tdata <= 32'd0;
        m_tuser <= ST_OVERFLOW;
      end else if (quo.quo[31:0] == 32'd0) begin
        m_tdata <= 32'd0;
        m_tuser <= ST_INVALID;
      end else begin
        m_tdata <= quo.quo[31:0];
        m_tuser <= ST_OK;
      end
    end
  end

endmodule
`default_nettype wire

// File: verif/lora_packet_airtime_top_tb.sv
`default_nettype none
module lora_packet_airtime_top_tb;
  import lpa_pkg::*;

  // expected airtime results, oldest first
  class airtime_board;
    logic [31:0] want_ms[$];
    logic [1:0]  want_st[$];
    int          errors;

    function void note_len(input logic [31:0] ms, input logic [1:0] st);
      want_ms.push_back(ms);
      want_st.push_back(st);
    endfunction

    function void check_result(input logic [31:0] ms, input logic [1:0] st);
      logic [31:0] ems;
      logic [1:0]  est;
      if (want_ms.size() == 0) begin
        $error("unexpected result airtime_ms=%0d status=%0d", ms, st);
        errors++;
      end else begin
        ems = want_ms.pop_front();
        est = want_st.pop_front();
        if (ems !== ms) begin
          $error("airtime_ms expected %0d actual %0d", ems, ms);
          errors++;
        end
        if (est !== st) begin
          $error("status expected %0d actual %0d", est, st);
          errors++;
        end
      end
    endfunction

    function int pending();
      return want_ms.size();
    endfunction
  endclass

  logic        clk = 0;
  logic        rst = 1;
  logic        cfg_we = 0;
  logic [2:0]  cfg_index = '0;
  logic [18:0] cfg_data = '0;
  logic        s_tvalid = 0;
  logic        s_tready;
  logic [7:0]  s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 0;
  logic [31:0] m_tdata;
  logic [1:0]  m_tuser;

  lora_packet_airtime_top dut (.*);

  always #5 clk = ~clk;

  airtime_board board = new();
  cfg_t modem;
  int   quiet_cycles = 0;
  int   stall_long = 0;
  int   hold_asks = 0;
  int   hold_done = 0;
  bit   calm = 0;

  // snapped bandwidth for the predictor
  function automatic logic [18:0] std_bw(input logic [18:0] raw);
    case (raw)
      19'd7800, 19'd7812:   return 19'd7812;
      19'd10400, 19'd10417: return 19'd10417;
      19'd15600, 19'd15625: return 19'd15625;
      19'd20800, 19'd20833: return 19'd20833;
      19'd31250:            return 19'd31250;
      19'd41667, 19'd41700: return 19'd41667;
      19'd62500:            return 19'd62500;
      19'd125000:           return 19'd125000;
      19'd250000:           return 19'd250000;
      19'd500000:           return 19'd500000;
      default:              return 19'd0;
    endcase
  endfunction

  // time on air for one payload under the current modem settings
  task automatic predict_airtime(input logic [7:0] len);
    logic [18:0] bw;
    logic        low_sf, ldro;
    logic [63:0] sym, coded, quarters, num, bw4, t;
    int          bits, den;
    bw = std_bw(modem.bw_hz);
    if (bw == 0 || modem.sf < 5 || modem.sf > 12 || modem.cr < 5 || modem.cr > 8 ||
        modem.pre == 0 || (!modem.expl && (modem.fixlen == 0 || len != modem.fixlen))) begin
      board.note_len(32'd0, ST_INVALID);
      return;
    end
    low_sf = modem.sf <= 6;
    sym = 64'd1 << modem.sf;
    ldro = sym * 64'd1000000 >= 64'(bw) * 64'd16000;
    bits = 8 * int'(len) - 4 * int'(modem.sf) + (modem.crc ? 16 : 0);
    if (low_sf) bits += modem.expl ? 20 : 0;
    else bits += modem.expl ? 28 : 8;
    den = 4 * (int'(modem.sf) - ((!low_sf && ldro) ? 2 : 0));
    coded = 0;
    if (bits > 0) coded = 64'((bits + den - 1) / den) * modem.cr;
    quarters = 64'(modem.pre) * 4 + (low_sf ? 57 : 49) + coded * 4;
    num = quarters * sym * 1000;
    bw4 = 64'(bw) * 4;
    t = (num + bw4 - 1) / bw4;
    if (t > 64'hFFFF_FFFF) board.note_len(32'd0, ST_OVERFLOW);
    else if (t == 0) board.note_len(32'd0, ST_INVALID);
    else board.note_len(t[31:0], ST_OK);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [18:0] val);
    s_tvalid <= 0;
    cfg_we <= 1; cfg_index <= idx; cfg_data <= val;
    @(posedge clk);
    case (idx)
      REG_BW:     modem.bw_hz = val;
      REG_SF:     modem.sf = val[3:0];
      REG_CR:     modem.cr = val[3:0];
      REG_PRE:    modem.pre = val[15:0];
      REG_CRC:    modem.crc = val[0];
      REG_EXPL:   modem.expl = val[0];
      REG_FIXLEN: modem.fixlen = val[7:0];
      default: ;
    endcase
  endtask

  task automatic send_len(input logic [7:0] len, input bit gaps);
    cfg_we <= 0;
    if (gaps && !calm && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    s_tvalid <= 1; s_tdata <= len;
    do @(posedge clk); while (!s_tready);
    predict_airtime(len);
  endtask

  // wait for every result, then let the pipe drain
  task automatic settle();
    s_tvalid <= 0;
    cfg_we <= 0;
    while (board.pending() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic random_modem(input bit sane);
    logic [18:0] bws[10] = '{7800, 10417, 15600, 20833, 31250, 41700, 62500,
                             125000, 250000, 500000};
    write_reg(REG_BW, (sane || $urandom_range(0, 5) != 0) ? bws[$urandom_range(0, 9)]
                                                           : 19'($urandom));
    write_reg(REG_SF, 19'(sane ? $urandom_range(5, 12) : $urandom_range(0, 15)));
    write_reg(REG_CR, 19'(sane ? $urandom_range(5, 8) : $urandom_range(0, 15)));
    write_reg(REG_PRE, ($urandom_range(0, 7) == 0) ? {3'd0, 16'($urandom)}
                                                   : 19'($urandom_range(sane, 20)));
    write_reg(REG_CRC, 19'($urandom_range(0, 1)));
    write_reg(REG_EXPL, 19'($urandom_range(0, 3) != 0));
    write_reg(REG_FIXLEN, 19'($urandom_range(0, 255)));
  endtask

  // result side with random stalls and one long hold-off
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 0;
    end else begin
      if (m_tvalid && m_tready) board.check_result(m_tdata, m_tuser);
      if (hold_asks != hold_done) begin
        hold_done <= hold_asks;
        stall_long <= 300;
        m_tready <= 0;
      end else if (stall_long > 0) begin
        stall_long <= stall_long - 1;
        m_tready <= 0;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        stall_long <= $urandom_range(1, 16);
        m_tready <= 0;
      end else begin
        m_tready <= 1;
      end
    end
  end

  // watchdog on accepted transfers
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > 5000) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    modem = '{bw_hz: 125000, sf: 7, cr: 5, pre: 8, crc: 1, expl: 1, fixlen: 0};
    repeat (8) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed: reset settings, length extremes
    foreach (s_tdata[i]) send_len(8'(1 << i), 0);
    send_len(8'd0, 0); send_len(8'd255, 0);
    settle();
    // slowest valid corner, long preamble
    write_reg(REG_BW, 7800); write_reg(REG_SF, 12); write_reg(REG_CR, 8);
    write_reg(REG_PRE, 16'hFFFF);
    send_len(8'd255, 0);
    settle();
    // small spreading factor, implicit header, match and mismatch
    write_reg(REG_BW, 500000); write_reg(REG_SF, 5); write_reg(REG_PRE, 1);
    write_reg(REG_CRC, 0); write_reg(REG_EXPL, 0); write_reg(REG_FIXLEN, 10);
    send_len(8'd10, 0); send_len(8'd11, 0); send_len(8'd0, 0);
    settle();
    write_reg(REG_SF, 6);
    send_len(8'd10, 0);
    settle();
    write_reg(REG_FIXLEN, 0); send_len(8'd0, 0);
    settle();
    // invalid settings
    write_reg(REG_EXPL, 1); write_reg(REG_BW, 7801); send_len(8'd3, 0);
    settle();
    write_reg(REG_BW, 41667); write_reg(REG_SF, 4); send_len(8'd3, 0);
    settle();
    write_reg(REG_SF, 13); send_len(8'd3, 0);
    settle();
    write_reg(REG_SF, 8); write_reg(REG_CR, 4); send_len(8'd3, 0);
    settle();
    write_reg(REG_CR, 9); send_len(8'd3, 0);
    settle();
    write_reg(REG_CR, 5); write_reg(REG_PRE, 0); send_len(8'd3, 0);
    settle();
    // long receiver hold-off while lengths keep coming
    write_reg(REG_PRE, 8);
    hold_asks++;
    repeat (100) send_len(8'($urandom), 0);
    settle();

    // random phases
    for (int ph = 0; ph < 25; ph++) begin
      random_modem($urandom_range(0, 3) != 0);
      if (ph >= 20) calm = 1;
      repeat (30) send_len(modem.expl || $urandom_range(0, 3) == 0 ? 8'($urandom)
                                                                 : modem.fixlen, 1);
      settle();
    end

    if (board.errors == 0 && board.pending() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule
`default_nettype wire

// File: files.f
rtl/core/lpa_pkg.sv
rtl/core/lpa_cfg.sv
rtl/core/lpa_sym.sv
rtl/core/lpa_div.sv
rtl/core/lora_packet_airtime_top.sv
verif/lora_packet_airtime_top_tb.sv
